/* rtl/core/psg_to_fm_register_translator_defines.svh */
// Assertion macros used by the checker file.
`ifndef PSG_TO_FM_REGISTER_TRANSLATOR_DEFINES_SVH
`define PSG_TO_FM_REGISTER_TRANSLATOR_DEFINES_SVH

// same-cycle implication
`define P2FM_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define P2FM_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/p2fm_pkg.sv */
package p2fm_pkg;

  localparam logic [30:0] SRC_CLOCK_RST = 31'd1789772;
  localparam logic [22:0] RATE_LIM      = 23'd7159090;  // 2 * 3579545
  localparam logic [21:0] RATE_DEN      = 22'd3579545;
  localparam logic [7:0]  FM_FNUM_BASE  = 8'hA0;
  localparam logic [7:0]  FM_BLK_BASE   = 8'hB0;
  localparam logic [7:0]  FM_ATT_BASE   = 8'h43;
  localparam logic [7:0]  FM_KEY_ON     = 8'h20;
  localparam logic [5:0]  ATT_MUTE      = 6'h3F;
  localparam logic [9:0]  FNUM_MAX      = 10'h3FF;
  localparam logic [2:0]  BLK_MAX       = 3'd7;
  localparam logic [3:0]  SRC_TONE_LAST = 4'd5;
  localparam logic [3:0]  SRC_MIXER     = 4'd7;
  localparam logic [3:0]  SRC_VOL_FIRST = 4'd8;
  localparam logic [3:0]  SRC_VOL_LAST  = 4'd10;
  localparam int unsigned DIV_STEPS     = 10;

  localparam logic [5:0] VOL_TAB0 [16] = '{
    6'd32, 6'd32, 6'd31, 6'd31, 6'd31, 6'd30, 6'd30, 6'd28,
    6'd28, 6'd25, 6'd24, 6'd22, 6'd20, 6'd18, 6'd16, 6'd13};
  localparam logic [5:0] VOL_TAB1 [16] = '{
    6'd10, 6'd10, 6'd10, 6'd9, 6'd9, 6'd9, 6'd9, 6'd9,
    6'd9,  6'd9,  6'd8,  6'd8, 6'd7, 6'd6, 6'd5, 6'd3};

  typedef struct packed {
    logic       load;
    logic       decode;
    logic       mul;
    logic       classify;
    logic       prep;
    logic       div_step;
    logic       fill;
    logic       out_load;
    logic [1:0] out_idx;
    logic       out_last;
  } p2fm_cmd_t;

  typedef struct packed {
    logic       tone_go;
    logic [1:0] imm_cnt;
    logic [1:0] res_cnt;
  } p2fm_sts_t;

  function automatic logic [5:0] vol_atten(input logic kind, input logic [3:0] vol);
    vol_atten = kind ? VOL_TAB1[vol] : VOL_TAB0[vol];
  endfunction

endpackage

/* rtl/core/p2fm_dp.sv */
module p2fm_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  p2fm_pkg::p2fm_cmd_t cmd_i,
  output p2fm_pkg::p2fm_sts_t sts_o,
  input  logic [30:0]         src_clock_i,
  input  logic                chip_kind_i,
  input  logic [3:0]          reg_addr_i,
  input  logic [7:0]          reg_data_i,
  output logic [7:0]          fm_addr_o,
  output logic [7:0]          fm_data_o,
  output logic                last_write_o
);
  import p2fm_pkg::*;

  logic [3:0]  addr_q;
  logic [7:0]  data_q;
  logic [7:0]  tone_q [6];
  logic [12:0] last_per_q [3];   // top bit marks "never seen"
  logic [3:0]  last_vol_q [3];
  logic [5:0]  atten_q [3];
  logic [7:0]  mask_q;

  logic [7:0]  res_addr_q [3];
  logic [7:0]  res_data_q [3];
  logic [1:0]  res_cnt_q;

  logic [11:0] p_q;
  logic [1:0]  tch_q;
  logic [34:0] p9c_q, lim_q;
  logic [18:0] p110_q;
  logic [19:0] p220_q;
  logic [33:0] den_q;
  logic        zero_q, top_q, ovf_q;
  logic [2:0]  blk_q;
  logic [55:0] rem_q, div_q;
  logic [9:0]  quo_q;
  logic [7:0]  fm_addr_q, fm_data_q;
  logic        last_q;

  // decode
  logic [1:0]  tch;
  logic [7:0]  lo, hi;
  logic [11:0] period;
  logic        is_tone, is_vol, tone_go, vol_chg;
  logic [1:0]  vch;
  logic [5:0]  att_new;
  logic [7:0]  diff;
  logic [7:0]  e_addr [3];
  logic [7:0]  e_data [3];
  logic [1:0]  imm_cnt;

  always_comb begin
    tch     = addr_q[2:1];
    lo      = addr_q[0] ? tone_q[{tch, 1'b0}] : data_q;
    hi      = addr_q[0] ? data_q : tone_q[{tch, 1'b1}];
    period  = {hi[3:0], lo};
    is_tone = addr_q <= SRC_TONE_LAST;
    tone_go = is_tone && ({1'b0, period} != last_per_q[tch]);
    is_vol  = (addr_q >= SRC_VOL_FIRST) && (addr_q <= SRC_VOL_LAST);
    vch     = addr_q[1:0];
    vol_chg = is_vol && (data_q[3:0] != last_vol_q[vch]);
    att_new = vol_atten(chip_kind_i, data_q[3:0]);
    diff    = mask_q ^ data_q;
    imm_cnt = 2'd0;
    for (int i = 0; i < 3; i++) begin
      e_addr[i] = 8'h00;
      e_data[i] = 8'h00;
    end
    if (addr_q == SRC_MIXER) begin
      for (int c = 0; c < 3; c++) begin
        if (diff[c]) begin
          e_addr[imm_cnt] = FM_ATT_BASE + 8'(c);
          e_data[imm_cnt] = {2'b00, data_q[c] ? ATT_MUTE : atten_q[c]};
          imm_cnt         = imm_cnt + 2'd1;
        end
      end
    end else if (vol_chg) begin
      e_addr[0] = FM_ATT_BASE + {6'b0, vch};
      e_data[0] = {2'b00, mask_q[vch] ? ATT_MUTE : att_new};
      imm_cnt   = 2'd1;
    end
  end

  // frequency classification and divider setup
  logic [2:0]  blk_c;
  logic [55:0] rem_c, d2_c;
  always_comb begin
    blk_c = 3'd0;
    for (int k = 1; k <= 7; k++) begin
      if ({4'b0, src_clock_i} >= (35'(p220_q) << k)) blk_c = 3'(k);
    end
    rem_c = (56'(p9c_q) << (5'd20 - {2'b0, blk_q})) + 56'(den_q);
    d2_c  = 56'(den_q) << 1;
  end

  logic [9:0] fn;
  logic [2:0] blk;
  always_comb begin
    if (zero_q) begin
      fn  = 10'd0;
      blk = 3'd0;
    end else if (top_q) begin
      fn  = FNUM_MAX;
      blk = BLK_MAX;
    end else begin
      fn  = ovf_q ? FNUM_MAX : quo_q;
      blk = blk_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) tone_q[i] <= 8'h00;
      for (int i = 0; i < 3; i++) begin
        last_per_q[i] <= 13'h1FFF;
        last_vol_q[i] <= 4'h0;
        atten_q[i]    <= VOL_TAB0[0];
      end
      mask_q    <= 8'hFF;
      res_cnt_q <= 2'd0;
    end else begin
      if (cmd_i.decode) begin
        if (is_tone) tone_q[addr_q[2:0]] <= data_q;
        if (tone_go) last_per_q[tch] <= {1'b0, period};
        if (addr_q == SRC_MIXER) mask_q <= data_q;
        if (vol_chg) begin
          last_vol_q[vch] <= data_q[3:0];
          atten_q[vch]    <= att_new;
        end
        res_cnt_q <= imm_cnt;
      end
      if (cmd_i.fill) res_cnt_q <= 2'd2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q <= reg_addr_i;
      data_q <= reg_data_i;
    end
    if (cmd_i.decode) begin
      p_q   <= period;
      tch_q <= tch;
      for (int i = 0; i < 3; i++) begin
        res_addr_q[i] <= e_addr[i];
        res_data_q[i] <= e_data[i];
      end
    end
    if (cmd_i.mul) begin
      p9c_q  <= (35'(src_clock_i) << 3) + 35'(src_clock_i);
      lim_q  <= 35'(RATE_LIM) * 35'(p_q);
      p110_q <= 19'(p_q) * 19'd110;
      p220_q <= 20'(p_q) * 20'd220;
      den_q  <= 34'(RATE_DEN) * 34'(p_q);
    end
    if (cmd_i.classify) begin
      zero_q <= (p_q == 12'd0) || (p9c_q > lim_q) || (src_clock_i <= 31'(p110_q));
      top_q  <= {4'b0, src_clock_i} >= (35'(p220_q) << 8);
      blk_q  <= blk_c;
    end
    if (cmd_i.prep) begin
      rem_q <= rem_c;
      div_q <= d2_c << (DIV_STEPS - 1);
      ovf_q <= rem_c >= (d2_c << DIV_STEPS);
      quo_q <= 10'd0;
    end
    if (cmd_i.div_step) begin
      if (rem_q >= div_q) begin
        rem_q <= rem_q - div_q;
        quo_q <= {quo_q[8:0], 1'b1};
      end else begin
        quo_q <= {quo_q[8:0], 1'b0};
      end
      div_q <= div_q >> 1;
    end
    if (cmd_i.fill) begin
      res_addr_q[0] <= FM_FNUM_BASE | {6'b0, tch_q};
      res_data_q[0] <= fn[7:0];
      res_addr_q[1] <= FM_BLK_BASE | {6'b0, tch_q};
      res_data_q[1] <= FM_KEY_ON | {3'b0, blk, fn[9:8]};
    end
    if (cmd_i.out_load) begin
      fm_addr_q <= res_addr_q[cmd_i.out_idx];
      fm_data_q <= res_data_q[cmd_i.out_idx];
      last_q    <= cmd_i.out_last;
    end
  end

  assign sts_o.tone_go = tone_go;
  assign sts_o.imm_cnt = imm_cnt;
  assign sts_o.res_cnt = res_cnt_q;
  assign fm_addr_o     = fm_addr_q;
  assign fm_data_o     = fm_data_q;
  assign last_write_o  = last_q;

endmodule

/* rtl/core/p2fm_ctrl.sv */
module p2fm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output p2fm_pkg::p2fm_cmd_t cmd_o,
  input  p2fm_pkg::p2fm_sts_t sts_i
);
  import p2fm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DECODE, ST_MUL, ST_CLASS, ST_PREP, ST_DIV, ST_FILL, ST_EMIT
  } state_e;

  state_e     state_q;
  logic [3:0] step_q;
  logic [1:0] idx_q;
  logic       out_valid_q;

  logic free, last;
  assign free = !out_valid_q || !out_stall_i;
  assign last = idx_q == (sts_i.res_cnt - 2'd1);

  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.decode   = state_q == ST_DECODE;
    cmd_o.mul      = state_q == ST_MUL;
    cmd_o.classify = state_q == ST_CLASS;
    cmd_o.prep     = state_q == ST_PREP;
    cmd_o.div_step = state_q == ST_DIV;
    cmd_o.fill     = state_q == ST_FILL;
    cmd_o.out_load = (state_q == ST_EMIT) && free;
    cmd_o.out_idx  = idx_q;
    cmd_o.out_last = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= 4'd0;
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE:   if (in_valid_i) state_q <= ST_DECODE;
        ST_DECODE: begin
          idx_q <= 2'd0;
          if (sts_i.tone_go) state_q <= ST_MUL;
          else if (sts_i.imm_cnt != 2'd0) state_q <= ST_EMIT;
          else state_q <= ST_IDLE;
        end
        ST_MUL:    state_q <= ST_CLASS;
        ST_CLASS:  state_q <= ST_PREP;
        ST_PREP: begin
          step_q  <= 4'd0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'(DIV_STEPS - 1)) state_q <= ST_FILL;
        end
        ST_FILL:   state_q <= ST_EMIT;
        ST_EMIT: begin
          if (free) begin
            idx_q <= idx_q + 2'd1;
            if (last) state_q <= ST_IDLE;
          end
        end
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != ST_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

/* rtl/core/psg_to_fm_register_translator.sv */
// A volume or mixer write is decoded and its results are emitted directly; a tone period
//   change also passes multiply, classify, divider prep, a 10-step divider and fill.
// One input beat at a time: in_stall_o stays high until the beat's last result is loaded
//   into the output register, also while the output side stalls; a beat with no results frees it after decode.
// Reset (rst_ni, async, active low): translation state returns to power-on values,
//   source_clock to 1789772, chip_kind to 0; no clearing pass.
module psg_to_fm_register_translator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // source register writes
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [3:0]  reg_addr_i,
  input  logic [7:0]  reg_data_i,
  // FM register writes
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  fm_addr_o,
  output logic [7:0]  fm_data_o,
  output logic        last_write_o
);
  import p2fm_pkg::*;

  // Register map: 0x0 source_clock (31 bits), 0x4 chip_kind (1 bit).
  // Only paddr[2] is decoded, so the low address bits alias.
  logic [30:0] src_clock_q;
  logic        chip_kind_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_clock_q <= SRC_CLOCK_RST;
      chip_kind_q <= 1'b0;
    end else if (wr_en) begin
      if (paddr[2]) chip_kind_q <= pwdata[0];
      else src_clock_q <= pwdata[30:0];
    end
  end

  assign prdata = paddr[2] ? {31'b0, chip_kind_q} : {1'b0, src_clock_q};

  // Controller sequences decode, frequency maths and output beats; the
  // datapath holds the shadow registers, the divider and the result slots.
  p2fm_cmd_t cmd;
  p2fm_sts_t sts;

  p2fm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  p2fm_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .src_clock_i  (src_clock_q),
    .chip_kind_i  (chip_kind_q),
    .reg_addr_i   (reg_addr_i),
    .reg_data_i   (reg_data_i),
    .fm_addr_o    (fm_addr_o),
    .fm_data_o    (fm_data_o),
    .last_write_o (last_write_o)
  );

endmodule

/* rtl/core/p2fm_checker.sv */
`include "psg_to_fm_register_translator_defines.svh"

module p2fm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [7:0]  fm_addr_o,
  input logic [7:0]  fm_data_o,
  input logic        last_write_o
);

  `P2FM_ASSERT_NXT(a_busy_after_in, in_valid_i && !in_stall_o, in_stall_o, "input beat not followed by busy")
  `P2FM_ASSERT_NXT(a_burst_cont, out_valid_o && !out_stall_i && !last_write_o, out_valid_o, "result burst broken")
  `P2FM_ASSERT_IMP(a_busy_in_burst, out_valid_o && !last_write_o, in_stall_o, "input taken mid burst")
  `P2FM_ASSERT_NXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(fm_addr_o) && $stable(fm_data_o), "stalled output beat changed")

endmodule

bind psg_to_fm_register_translator p2fm_checker u_p2fm_checker (.*);
